>>> sv/escaped_uart_gap_framer_defines.svh
// assertion helpers for the framer
`ifndef ESCAPED_UART_GAP_FRAMER_DEFINES_SVH
`define ESCAPED_UART_GAP_FRAMER_DEFINES_SVH
`define EUGF_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("failed");
`define EUGF_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("failed");
`endif

>>> sv/eugf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package eugf_pkg;
  localparam int RX_DEPTH = 256;
  localparam int TX_DEPTH = 256;
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int QD = 2;

  localparam logic [2:0] OP_RX    = 3'd0;
  localparam logic [2:0] OP_TXRDY = 3'd1;
  localparam logic [2:0] OP_TXIDL = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_PUT   = 3'd4;
  localparam logic [2:0] OP_BRK   = 3'd5;
  localparam logic [2:0] OP_GET   = 3'd6;

  localparam logic [2:0] REG_RXLEN = 3'd0;
  localparam logic [2:0] REG_TXLEN = 3'd1;
  localparam logic [2:0] REG_ESC   = 3'd2;
  localparam logic [2:0] REG_GAP   = 3'd3;
  localparam logic [2:0] REG_RXGAP = 3'd4;
  localparam logic [2:0] REG_GUARD = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_gap;
    logic [7:0] rx_fill;
    logic [7:0] quiet_ticks;
    logic       tx_busy;
    logic       tx_paused;
    logic       tx_ready_irq_on;
    logic       tx_idle_irq_on;
    logic       dropped;
  } res_t;

  function automatic logic [8:0] clamp_len(input logic [8:0] v, input int depth);
    logic [8:0] r;
    r = v;
    if (v < 9'd2) r = 9'd2;
    else if (int'(v) > depth) r = 9'(depth);
    return r;
  endfunction
endpackage
`default_nettype wire

>>> sv/eugf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// accepts requests into a short queue
module eugf_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         operation,
  input  wire logic [7:0]         data_byte,
  output logic                    q_valid,
  output eugf_pkg::cmd_t          q_cmd,
  input  wire logic               q_take
);
  eugf_pkg::cmd_t slot [eugf_pkg::QD];
  logic [0:0] wp, rp;
  logic [1:0] cnt;
  logic push, pop;

  assign in_ready = (cnt != 2'(eugf_pkg::QD));
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = slot[rp];
  assign push = in_valid && in_ready;
  assign pop = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= '{op: operation, data: data_byte};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

>>> sv/eugf_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "escaped_uart_gap_framer_defines.svh"
// sequencer: each request takes zero or more ring accesses
module eugf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire eugf_pkg::cmd_t q_cmd,
  output logic                q_take,
  input  wire logic [8:0]     rx_length,
  input  wire logic [8:0]     tx_length,
  input  wire logic [7:0]     esc,
  input  wire logic [7:0]     gap,
  input  wire logic [7:0]     rx_gap_ticks,
  input  wire logic [7:0]     guard,
  output logic                res_valid,
  output eugf_pkg::res_t      res,
  input  wire logic           res_ready
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD1  = 4'b0010,
    S_RD2  = 4'b0100,
    S_WR2  = 4'b1000
  } st_t;
  typedef enum logic [1:0] { K_TXADV, K_GET, K_RXPAIR, K_TXPAIR } kind_t;

  st_t state;
  kind_t kind;
  logic [7:0] rx_store [eugf_pkg::RX_DEPTH];
  logic [7:0] tx_store [eugf_pkg::TX_DEPTH];
  logic [eugf_pkg::RX_AW-1:0] rx_head, rx_tail, rx_p1;
  logic [eugf_pkg::TX_AW-1:0] tx_head, tx_tail, tx_p1;
  logic [7:0] pair_b;
  logic sending, paused, rx_seen;
  logic [7:0] quiet, wait_cnt;
  logic [1:0] irq;
  logic [7:0] rx_rd, tx_rd;
  logic drop;
  logic [8:0] rlen, tlen;
  logic out_full;
  logic snd_v, rd_v, rd_g;
  logic [7:0] snd_b, rd_b;
  logic rx_drop, tx_drop, gap_ins, adv_now, put_direct, go_multi, fin, adv_pend;

  assign rlen = eugf_pkg::clamp_len(rx_length, eugf_pkg::RX_DEPTH);
  assign tlen = eugf_pkg::clamp_len(tx_length, eugf_pkg::TX_DEPTH);

  function automatic logic [eugf_pkg::RX_AW-1:0] radv(input logic [eugf_pkg::RX_AW-1:0] i,
                                                     input logic [8:0] len);
    logic [8:0] n;
    n = {1'b0, i} + 9'd1;
    return (n >= len) ? '0 : n[eugf_pkg::RX_AW-1:0];
  endfunction
  function automatic logic [eugf_pkg::TX_AW-1:0] tadv(input logic [eugf_pkg::TX_AW-1:0] i,
                                                     input logic [8:0] len);
    logic [8:0] n;
    n = {1'b0, i} + 9'd1;
    return (n >= len) ? '0 : n[eugf_pkg::TX_AW-1:0];
  endfunction

  logic [eugf_pkg::RX_AW-1:0] rh1, rh2, rt1;
  logic [eugf_pkg::TX_AW-1:0] th1, th2, tt1;
  assign rh1 = radv(rx_head, rlen);
  assign rh2 = radv(rh1, rlen);
  assign rt1 = radv(rx_tail, rlen);
  assign th1 = tadv(tx_head, tlen);
  assign th2 = tadv(th1, tlen);
  assign tt1 = tadv(tx_tail, tlen);

  // a tail past the head by more than the ring length reads as empty
  logic [8:0] fdiff;
  logic [7:0] fill;
  always_comb begin
    fdiff = {1'b0, rx_tail} - {1'b0, rx_head};
    if (rx_head >= rx_tail) fill = rx_head - rx_tail;
    else if (fdiff > rlen) fill = 8'd0;
    else fill = 8'(rlen - fdiff);
  end

  assign out_full = res_valid && !res_ready;
  assign q_take = (state == S_IDLE) && q_valid && !out_full;

  // tick quiet value as seen after this tick
  logic [7:0] quiet_n, wait_n;
  always_comb begin
    if (rx_seen) quiet_n = 8'd0;
    else if (quiet != 8'd255) quiet_n = quiet + 8'd1;
    else quiet_n = quiet;
    wait_n = (wait_cnt != 8'd255) ? wait_cnt + 8'd1 : wait_cnt;
  end

  // decisions for the request at the head of the queue
  always_comb begin
    rx_drop = 1'b0;
    tx_drop = 1'b0;
    gap_ins = 1'b0;
    adv_now = 1'b0;
    put_direct = 1'b0;
    go_multi = 1'b0;
    case (q_cmd.op)
      eugf_pkg::OP_RX: begin
        rx_drop = (rh1 == rx_tail) || (q_cmd.data == esc && rh2 == rx_tail);
        go_multi = (q_cmd.data == esc) && !rx_drop;
      end
      eugf_pkg::OP_TXRDY: go_multi = irq[0] && (tx_head != tx_tail);
      eugf_pkg::OP_TICK: begin
        if (quiet_n == rx_gap_ticks) begin
          rx_drop = (rh1 == rx_tail) || (rh2 == rx_tail);
          gap_ins = !rx_drop;
        end
        adv_now = paused && (wait_n > guard) && (quiet_n > guard) && sending;
        go_multi = gap_ins || adv_now;
      end
      eugf_pkg::OP_PUT: begin
        put_direct = !sending && !paused;
        if (!put_direct) begin
          tx_drop = (th1 == tx_tail) || (q_cmd.data == esc && th2 == tx_tail);
          go_multi = (q_cmd.data == esc) && !tx_drop;
        end
      end
      eugf_pkg::OP_BRK: begin
        tx_drop = (th1 == tx_tail) || (th2 == tx_tail);
        go_multi = !tx_drop;
      end
      eugf_pkg::OP_GET: go_multi = (rx_head != rx_tail);
      default: ;
    endcase
  end

  // last cycle of a request
  always_comb begin
    case (state)
      S_IDLE: fin = q_take && !go_multi;
      S_WR2: begin
        case (kind)
          K_RXPAIR: fin = !adv_pend;
          K_TXPAIR: fin = 1'b1;
          default:  fin = (tx_head == tx_tail);
        endcase
      end
      S_RD1: fin = (kind == K_GET) ? !(rx_rd == esc && rx_head != rx_p1)
                                   : !(tx_rd == esc && tx_head != tx_p1);
      S_RD2: fin = 1'b1;
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (fin) res_valid <= 1'b1;
    else if (res_ready) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind <= K_TXADV;
      adv_pend <= 1'b0;
      rx_head <= '0; rx_tail <= '0; tx_head <= '0; tx_tail <= '0;
      sending <= 1'b0; paused <= 1'b0; rx_seen <= 1'b0;
      quiet <= '0; wait_cnt <= '0; irq <= '0;
      drop <= 1'b0;
      snd_v <= 1'b0; snd_b <= '0; rd_v <= 1'b0; rd_b <= '0; rd_g <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_take) begin
            snd_v <= put_direct;
            snd_b <= put_direct ? q_cmd.data : 8'd0;
            rd_v <= 1'b0; rd_b <= '0; rd_g <= 1'b0;
            drop <= rx_drop || tx_drop;
            case (q_cmd.op)
              eugf_pkg::OP_RX: begin
                rx_seen <= 1'b1;
                if (!rx_drop) begin
                  rx_store[rh1] <= q_cmd.data;
                  if (q_cmd.data == esc) begin
                    pair_b <= esc; rx_p1 <= rh2;
                    kind <= K_RXPAIR; state <= S_WR2;
                  end else rx_head <= rh1;
                end
              end
              eugf_pkg::OP_TXRDY: begin
                if (irq[0]) begin
                  if (tx_head == tx_tail) begin
                    sending <= 1'b0; irq <= 2'b10;
                  end else begin
                    tx_rd <= tx_store[tt1]; tx_p1 <= tt1;
                    kind <= K_TXADV; state <= S_RD1;
                  end
                end
              end
              eugf_pkg::OP_TXIDL: irq[1] <= 1'b0;
              eugf_pkg::OP_TICK: begin
                quiet <= quiet_n; rx_seen <= 1'b0;
                if (paused) begin
                  wait_cnt <= wait_n;
                  if (wait_n > guard && quiet_n > guard) paused <= 1'b0;
                end else wait_cnt <= 8'd0;
                // gap marker pair, tx advance follows if unpaused
                if (gap_ins) begin
                  rx_store[rh1] <= esc; pair_b <= gap; rx_p1 <= rh2;
                  adv_pend <= adv_now; kind <= K_RXPAIR; state <= S_WR2;
                end else if (adv_now) begin
                  kind <= K_TXADV; state <= S_WR2;
                end
              end
              eugf_pkg::OP_PUT: begin
                sending <= 1'b1;
                if (put_direct) irq[0] <= 1'b1;
                else if (!tx_drop) begin
                  tx_store[th1] <= q_cmd.data;
                  if (q_cmd.data == esc) begin
                    pair_b <= esc; tx_p1 <= th2;
                    kind <= K_TXPAIR; state <= S_WR2;
                  end else tx_head <= th1;
                end
              end
              eugf_pkg::OP_BRK: begin
                if (!tx_drop) begin
                  tx_store[th1] <= esc; pair_b <= gap; tx_p1 <= th2;
                  kind <= K_TXPAIR; state <= S_WR2;
                end
              end
              eugf_pkg::OP_GET: begin
                if (rx_head != rx_tail) begin
                  rx_rd <= rx_store[rt1]; rx_p1 <= rt1;
                  kind <= K_GET; state <= S_RD1;
                end
              end
              default: ;
            endcase
          end
        end
        S_WR2: begin
          case (kind)
            K_RXPAIR: begin
              rx_store[rx_p1] <= pair_b; rx_head <= rx_p1;
              adv_pend <= 1'b0;
              if (adv_pend) kind <= K_TXADV;
              else state <= S_IDLE;
            end
            K_TXPAIR: begin
              tx_store[tx_p1] <= pair_b; tx_head <= tx_p1;
              state <= S_IDLE;
            end
            default: begin
              // unpause: start a transmit advance
              if (tx_head == tx_tail) begin
                sending <= 1'b0; irq <= 2'b10; state <= S_IDLE;
              end else begin
                tx_rd <= tx_store[tt1]; tx_p1 <= tt1; state <= S_RD1;
              end
            end
          endcase
        end
        S_RD1: begin
          if (kind == K_GET) begin
            if (rx_rd == esc) begin
              if (rx_head == rx_p1) begin
                state <= S_IDLE;
              end else begin
                rx_rd <= rx_store[radv(rx_p1, rlen)];
                rx_p1 <= radv(rx_p1, rlen); state <= S_RD2;
              end
            end else begin
              rx_tail <= rx_p1; rd_v <= 1'b1; rd_b <= rx_rd;
              state <= S_IDLE;
            end
          end else begin
            if (tx_rd == esc) begin
              if (tx_head == tx_p1) begin
                tx_tail <= tx_p1; sending <= 1'b0; irq <= 2'b10;
                state <= S_IDLE;
              end else begin
                tx_rd <= tx_store[tadv(tx_p1, tlen)];
                tx_p1 <= tadv(tx_p1, tlen); state <= S_RD2;
              end
            end else begin
              tx_tail <= tx_p1; irq[0] <= 1'b1;
              snd_v <= 1'b1; snd_b <= tx_rd;
              state <= S_IDLE;
            end
          end
        end
        S_RD2: begin
          state <= S_IDLE;
          if (kind == K_GET) begin
            rx_tail <= rx_p1; rd_v <= 1'b1;
            if (rx_rd == gap) rd_g <= 1'b1;
            else rd_b <= rx_rd;
          end else begin
            tx_tail <= tx_p1;
            if (tx_rd == gap) begin
              paused <= 1'b1; irq <= 2'b10;
            end else begin
              irq[0] <= 1'b1; snd_v <= 1'b1; snd_b <= tx_rd;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res.send_valid = snd_v;
    res.send_byte = snd_b;
    res.read_valid = rd_v;
    res.read_byte = rd_b;
    res.read_gap = rd_g;
    res.rx_fill = fill;
    res.quiet_ticks = quiet;
    res.tx_busy = sending;
    res.tx_paused = paused;
    res.tx_ready_irq_on = irq[0];
    res.tx_idle_irq_on = irq[1];
    res.dropped = drop;
  end

  `EUGF_ASSERT(a_onehot, $onehot(state))
  `EUGF_ASSERT(a_take_idle, !q_take || (state == S_IDLE))
  `EUGF_ASSERT_IMP(a_rd2_done, state == S_RD2, state == S_IDLE && res_valid)
endmodule
`default_nettype wire

>>> sv/escaped_uart_gap_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// a new request is taken only when the last is done and no result is stalled;
// escape pairs, gap markers, unescaping and resumed transmit take extra ring accesses
// a two-entry request queue decouples acceptance from the sequencer
// reset: synchronous rst clears indices, flags, counters and registers to defaults
// ring contents are not cleared
module escaped_uart_gap_framer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] operation,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            send_valid,
  output logic [7:0]      send_byte,
  output logic            read_valid,
  output logic [7:0]      read_byte,
  output logic            read_gap,
  output logic [7:0]      rx_fill,
  output logic [7:0]      quiet_ticks,
  output logic            tx_busy,
  output logic            tx_paused,
  output logic            tx_ready_irq_on,
  output logic            tx_idle_irq_on,
  output logic            dropped,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [8:0] cfg_data
);
  logic [8:0] rx_length, tx_length;
  logic [7:0] esc, gap, rx_gap_ticks, guard;
  logic q_valid, q_take;
  eugf_pkg::cmd_t q_cmd;
  eugf_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_length <= 9'd256; tx_length <= 9'd256;
      esc <= 8'h72; gap <= 8'h01; rx_gap_ticks <= 8'd4; guard <= 8'd6;
    end else if (cfg_we) begin
      case (cfg_index)
        eugf_pkg::REG_RXLEN: rx_length <= cfg_data;
        eugf_pkg::REG_TXLEN: tx_length <= cfg_data;
        eugf_pkg::REG_ESC:   esc <= cfg_data[7:0];
        eugf_pkg::REG_GAP:   gap <= cfg_data[7:0];
        eugf_pkg::REG_RXGAP: rx_gap_ticks <= cfg_data[7:0];
        eugf_pkg::REG_GUARD: guard <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  eugf_front u_front (
    .clk, .rst, .in_valid, .in_ready, .operation, .data_byte,
    .q_valid, .q_cmd, .q_take
  );

  eugf_back u_back (
    .clk, .rst, .q_valid, .q_cmd, .q_take, .rx_length, .tx_length,
    .esc, .gap, .rx_gap_ticks, .guard,
    .res_valid(out_valid), .res, .res_ready(out_ready)
  );

  assign send_valid = res.send_valid;
  assign send_byte = res.send_byte;
  assign read_valid = res.read_valid;
  assign read_byte = res.read_byte;
  assign read_gap = res.read_gap;
  assign rx_fill = res.rx_fill;
  assign quiet_ticks = res.quiet_ticks;
  assign tx_busy = res.tx_busy;
  assign tx_paused = res.tx_paused;
  assign tx_ready_irq_on = res.tx_ready_irq_on;
  assign tx_idle_irq_on = res.tx_idle_irq_on;
  assign dropped = res.dropped;
endmodule
`default_nettype wire
